@@ src/mrsb_pkg.sv @@
// Package: shared types, constants and state encoding for the Miller-Rabin block.
`default_nettype none
package mrsb_pkg;
  localparam int unsigned WORD_BITS_DEF = 64;

  typedef struct packed {
    logic [63:0] witness_base;
    logic [63:0] odd_modulus;
  } in_req_t;

  typedef struct packed {
    logic probable_prime;
    logic bad_modulus;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SPLIT,
    ST_POW_MUL,
    ST_POW_MUL_W,
    ST_POW_SQR,
    ST_POW_SQR_W,
    ST_CHECK,
    ST_SQR,
    ST_SQR_W,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

@@ src/mrsb_modmul.sv @@
// Modular multiplier: shift-and-add ladder, one multiplier bit per cycle.
`default_nettype none
module mrsb_modmul #(
  parameter int unsigned WORD_BITS = mrsb_pkg::WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [WORD_BITS-1:0] x_in,
  input  wire logic [WORD_BITS-1:0] y_in,
  input  wire logic [WORD_BITS-1:0] m_in,
  output logic                      busy,
  output logic [WORD_BITS-1:0]      prod
);
  logic                 busy_r, busy_nxt;
  logic [WORD_BITS-1:0] x_r, x_nxt, y_r, y_nxt, acc_r, acc_nxt;

  function automatic logic [WORD_BITS-1:0] add_mod(input logic [WORD_BITS-1:0] a,
      input logic [WORD_BITS-1:0] b, input logic [WORD_BITS-1:0] m);
    logic [WORD_BITS-1:0] room;
    room = m - b;
    if (a >= room) begin
      add_mod = a - room;
    end else begin
      add_mod = a + b;
    end
  endfunction

  always_comb begin
    busy_nxt = busy_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      x_nxt    = x_in;
      y_nxt    = y_in;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (y_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (y_r[0]) begin
          acc_nxt = add_mod(acc_r, x_r, m_in);
        end
        x_nxt = add_mod(x_r, x_r, m_in);
        y_nxt = y_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = busy_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

@@ src/mrsb_modred.sv @@
// Modular reducer: restoring remainder, one quotient bit per cycle.
`default_nettype none
module mrsb_modred #(
  parameter int unsigned WORD_BITS = mrsb_pkg::WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [WORD_BITS-1:0] a_in,
  input  wire logic [WORD_BITS-1:0] m_in,
  output logic                      busy,
  output logic [WORD_BITS-1:0]      rem
);
  localparam int unsigned CW = $clog2(WORD_BITS + 1);
  logic                 busy_r, busy_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] a_r, a_nxt, rem_r, rem_nxt;
  logic [WORD_BITS:0]   sh;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    rem_nxt  = rem_r;
    sh       = {rem_r, a_r[WORD_BITS-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(WORD_BITS);
      a_nxt    = a_in;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (sh >= {1'b0, m_in}) begin
          sh = sh - {1'b0, m_in};
        end
        rem_nxt = sh[WORD_BITS-1:0];
        a_nxt   = a_r << 1;
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

@@ src/miller_rabin_single_base.sv @@
// Top level: Miller-Rabin strong probable prime test for one base.
// One request is taken at a time; ready is low while the test runs and while
// a result waits. A bad modulus raises out_valid on the cycle after the
// request is taken. Otherwise the base is reduced by a restoring divider that
// runs alongside the exponent split, which shifts one bit a cycle. Each modular
// product then runs on one shift-and-add multiplier, one significant multiplier
// bit per cycle. A test needs up to about 2*WORD_BITS products. The result is
// held in an output register until taken.
`default_nettype none
module miller_rabin_single_base #(
  parameter int unsigned WORD_BITS = mrsb_pkg::WORD_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mrsb_pkg::in_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mrsb_pkg::out_req_t     out_data
);
  localparam int unsigned CW = $clog2(WORD_BITS + 1);

  mrsb_pkg::state_t     st_r, st_nxt;
  logic [WORD_BITS-1:0] n_r, n_nxt, b_r, b_nxt, e_r, e_nxt, x_r, x_nxt;
  logic [CW-1:0]        s_r, s_nxt;
  logic                 ov_r, ov_nxt;
  mrsb_pkg::out_req_t   od_r, od_nxt;
  logic [WORD_BITS-1:0] nb, nm1;
  logic                 mul_start, mul_busy, red_start, red_busy;
  logic [WORD_BITS-1:0] mul_x, mul_y, prod, rem;

  assign nb  = in_data.odd_modulus[WORD_BITS-1:0];
  assign nm1 = n_r - 1'b1;

  mrsb_modmul #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk, .rst_n, .start(mul_start), .x_in(mul_x), .y_in(mul_y), .m_in(n_r),
    .busy(mul_busy), .prod
  );

  mrsb_modred #(.WORD_BITS(WORD_BITS)) u_red (
    .clk, .rst_n, .start(red_start), .a_in(in_data.witness_base[WORD_BITS-1:0]),
    .m_in(n_r), .busy(red_busy), .rem
  );

  assign in_ready = (st_r == mrsb_pkg::ST_IDLE) && !ov_r;

  always_comb begin
    st_nxt    = st_r;
    n_nxt     = n_r;
    b_nxt     = b_r;
    e_nxt     = e_r;
    x_nxt     = x_r;
    s_nxt     = s_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    mul_start = 1'b0;
    red_start = 1'b0;
    mul_x     = x_r;
    mul_y     = b_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      mrsb_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          n_nxt = nb;
          if (nb < WORD_BITS'(3) || !nb[0]) begin
            ov_nxt = 1'b1;
            od_nxt = '{probable_prime: 1'b0, bad_modulus: 1'b1};
          end else begin
            red_start = 1'b1;
            e_nxt     = nb - 1'b1;
            s_nxt     = '0;
            st_nxt    = mrsb_pkg::ST_SPLIT;
          end
        end
      end
      mrsb_pkg::ST_SPLIT: begin
        if (!e_r[0]) begin
          e_nxt = e_r >> 1;
          s_nxt = s_r + 1'b1;
        end else begin
          st_nxt = mrsb_pkg::ST_REDUCE;
        end
      end
      mrsb_pkg::ST_REDUCE: begin
        if (!red_busy) begin
          b_nxt  = rem;
          x_nxt  = WORD_BITS'(1);
          st_nxt = mrsb_pkg::ST_POW_MUL;
        end
      end
      mrsb_pkg::ST_POW_MUL: begin
        if (e_r == '0) begin
          st_nxt = mrsb_pkg::ST_CHECK;
          if (x_r == WORD_BITS'(1)) begin
            ov_nxt = 1'b1;
            od_nxt = '{probable_prime: 1'b1, bad_modulus: 1'b0};
            st_nxt = mrsb_pkg::ST_IDLE;
          end
        end else if (e_r[0]) begin
          mul_start = 1'b1;
          st_nxt    = mrsb_pkg::ST_POW_MUL_W;
        end else begin
          st_nxt = mrsb_pkg::ST_POW_SQR;
        end
      end
      mrsb_pkg::ST_POW_MUL_W: begin
        if (!mul_busy) begin
          x_nxt  = prod;
          st_nxt = mrsb_pkg::ST_POW_SQR;
        end
      end
      mrsb_pkg::ST_POW_SQR: begin
        mul_x     = b_r;
        mul_start = 1'b1;
        st_nxt    = mrsb_pkg::ST_POW_SQR_W;
      end
      mrsb_pkg::ST_POW_SQR_W: begin
        if (!mul_busy) begin
          b_nxt  = prod;
          e_nxt  = e_r >> 1;
          st_nxt = mrsb_pkg::ST_POW_MUL;
        end
      end
      mrsb_pkg::ST_CHECK: begin
        if (s_r == '0 || x_r == nm1) begin
          ov_nxt = 1'b1;
          od_nxt = '{probable_prime: (s_r != '0), bad_modulus: 1'b0};
          st_nxt = mrsb_pkg::ST_IDLE;
        end else begin
          st_nxt = mrsb_pkg::ST_SQR;
        end
      end
      mrsb_pkg::ST_SQR: begin
        mul_y     = x_r;
        mul_start = 1'b1;
        st_nxt    = mrsb_pkg::ST_SQR_W;
      end
      mrsb_pkg::ST_SQR_W: begin
        mul_y = x_r;
        if (!mul_busy) begin
          x_nxt  = prod;
          s_nxt  = s_r - 1'b1;
          st_nxt = mrsb_pkg::ST_CHECK;
        end
      end
      default: begin
        st_nxt = mrsb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mrsb_pkg::ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    n_r  <= n_nxt;
    b_r  <= b_nxt;
    e_r  <= e_nxt;
    x_r  <= x_nxt;
    s_r  <= s_nxt;
    od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule
`default_nettype wire

@@ tb/miller_rabin_single_base_checker.sv @@
// Checker: watches both channels, predicts each Miller-Rabin verdict and compares.
`default_nettype none
module miller_rabin_single_base_checker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire mrsb_pkg::in_req_t in_data,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire mrsb_pkg::out_req_t out_data,
  output int                     fail_count,
  output int                     pending_count,
  output int                     prime_count,
  output int                     bad_count
);
  timeunit 1ns;
  timeprecision 1ps;

  mrsb_pkg::out_req_t verdict_q[$];

  function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, x} * {64'd0, y};
    return 64'(prod % {64'd0, m});
  endfunction

  function automatic mrsb_pkg::out_req_t predict_verdict(mrsb_pkg::in_req_t req);
    mrsb_pkg::out_req_t r;
    logic [63:0] n, nm1, d, b, x, e;
    int s;
    r = '0;
    n = req.odd_modulus;
    if (n < 3 || !n[0]) begin
      r.bad_modulus = 1'b1;
      return r;
    end
    nm1 = n - 1;
    d = nm1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    b = req.witness_base % n;
    x = 64'd1;
    e = d;
    while (e != 0) begin
      if (e[0]) x = mulmod(x, b, n);
      b = mulmod(b, b, n);
      e = e >> 1;
    end
    if (x == 1) begin
      r.probable_prime = 1'b1;
    end else begin
      for (int i = 0; i < s; i++) begin
        if (x == nm1) begin
          r.probable_prime = 1'b1;
          break;
        end
        x = mulmod(x, x, n);
      end
    end
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending_count = 0;
    prime_count = 0;
    bad_count = 0;
  end

  always @(posedge clk) begin
    mrsb_pkg::out_req_t want;
    if (rst_n) begin
      if (in_valid && in_ready) verdict_q = {verdict_q, predict_verdict(in_data)};
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result %b/%b", out_data.probable_prime, out_data.bad_modulus);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (want.probable_prime) prime_count++;
          if (want.bad_modulus) bad_count++;
          if (out_data.probable_prime !== want.probable_prime) begin
            $error("probable_prime: expected %b, got %b", want.probable_prime,
                   out_data.probable_prime);
            fail_count++;
          end
          if (out_data.bad_modulus !== want.bad_modulus) begin
            $error("bad_modulus: expected %b, got %b", want.bad_modulus,
                   out_data.bad_modulus);
            fail_count++;
          end
        end
      end
      pending_count = verdict_q.size();
    end
  end
endmodule
`default_nettype wire

@@ tb/miller_rabin_single_base_tb.sv @@
// Testbench top: drives requests with idling phases and reports the verdict.
`default_nettype none
module miller_rabin_single_base_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 40_000_000;
  localparam int unsigned RANDOM_ITEMS = 560;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mrsb_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mrsb_pkg::out_req_t out_data;
  int fail_count, pending_count, prime_count, bad_count;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;
  int sent = 0;
  longint unsigned cycles = 0;

  logic [63:0] primes[6] = '{64'hFFFF_FFFF_FFFF_FFC5, 64'h1FFF_FFFF_FFFF_FFFF,
                             64'd1000000007, 64'd65537, 64'd97, 64'd4294967291};
  logic [63:0] pseudos[5] = '{64'd2047, 64'd3277, 64'd561, 64'd1373653, 64'd25326001};

  always #1 clk = ~clk;

  miller_rabin_single_base dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  miller_rabin_single_base_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .prime_count(prime_count), .bad_count(bad_count)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("miller_rabin_single_base verification failed");
      $finish;
    end
  end

  // hold off the result channel during the long stall, otherwise stall at random
  always @(negedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  task automatic send(logic [63:0] base, logic [63:0] modulus);
    mrsb_pkg::in_req_t req;
    req.witness_base = base;
    req.odd_modulus = modulus;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_random();
    logic [63:0] n, b;
    int kind;
    kind = $urandom_range(9);
    b = {$urandom, $urandom};
    case (kind)
      0, 1: n = {$urandom, $urandom} | 64'd1;
      2, 3: n = primes[$urandom_range(5)];
      4: n = pseudos[$urandom_range(4)];
      5: n = 64'($urandom_range(65535)) | 64'd1;
      6: begin
        n = {$urandom, $urandom} | 64'd1;
        b = ($urandom_range(1)) ? n - 1 : n + 1;
      end
      7: n = {$urandom, $urandom} & ~64'd1;
      8: begin
        n = primes[$urandom_range(5)];
        b = 64'($urandom_range(3)) * n;
      end
      default: n = 64'($urandom_range(4));
    endcase
    if (kind == 4 && $urandom_range(1)) b = 64'd2;
    send(b, n);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(64'd5, 64'd0);
    send(64'd5, 64'd1);
    send(64'd5, 64'd2);
    send(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
    send(64'd0, 64'd3);
    send(64'd2, 64'd3);
    send(64'd97, 64'd97);
    send(64'd1, 64'd1000000007);
    send(64'd1000000006, 64'd1000000007);
    send(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send(64'd0, 64'hFFFF_FFFF_FFFF_FFC5);
    send(64'd2, 64'hFFFF_FFFF_FFFF_FFC5);
    send(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5);
    send(64'hFFFF_FFFF_FFFF_FFC4, 64'hFFFF_FFFF_FFFF_FFC5);
    send(64'd2, 64'h1FFF_FFFF_FFFF_FFFF);
    send(64'd2, 64'd2047);
    send(64'd3, 64'd2047);
    send(64'd2, 64'd561);
    send(64'd2, 64'd25326001);
    send(64'd7, 64'd65537);
    in_valid <= 1'b0;

    // drain before the stall test
    while (pending_count != 0) @(negedge clk);
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        send(64'd5, 64'd4);
        repeat (3) send_random();
      end
    join

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 56; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 56; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) send_random();
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("sent %0d requests over four idling phases and a long output stall", sent);
    $display("predicted %0d probable primes and %0d bad moduli", prime_count, bad_count);
    if (fail_count == 0)
      $display("miller_rabin_single_base verification clean");
    else
      $display("miller_rabin_single_base verification failed");
    $finish;
  end
endmodule
`default_nettype wire
